// ----- src/wetai_pkg.sv -----
// shared types and constants for the waveform edge time and integral block
`default_nettype none
package wetai_pkg;

    // field widths fixed by the stream format
    localparam int SampleBits = 16;
    localparam int IndexBits  = 12;
    localparam int SumBits    = 28;
    localparam int CfgIdxBits = 2;
    localparam int CfgBits    = 16;

    // configuration register indexes
    localparam logic [CfgIdxBits-1:0] CfgThreshold   = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgWindowFirst = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgWindowLast  = 2'd2;

    // register reset values
    localparam logic [IndexBits-1:0] WindowLastReset = 12'hFFF;

    // saturation limits of the window sum
    localparam logic signed [SumBits-1:0] SumHigh = {1'b0, {(SumBits-1){1'b1}}};
    localparam logic signed [SumBits-1:0] SumLow  = {1'b1, {(SumBits-1){1'b0}}};

    // one finished waveform result
    typedef struct packed {
        logic                        edge_found;
        logic [IndexBits-1:0]        edge_index;
        logic signed [SumBits-1:0]   window_sum;
    } t_result;

    // configuration seen by the core
    typedef struct packed {
        logic signed [SampleBits-1:0] threshold;
        logic [IndexBits-1:0]         window_first;
        logic [IndexBits-1:0]         window_last;
    } t_cfg;

endpackage
`default_nettype wire

// ----- src/wetai_in_stage.sv -----
// input register stage holding one sample request
`default_nettype none
module wetai_in_stage (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [wetai_pkg::SampleBits-1:0] i_sample,
    input  wire logic                                i_last,
    input  wire logic                                i_advance,
    output logic                                     o_valid,
    output logic signed [wetai_pkg::SampleBits-1:0]  o_sample,
    output logic                                     o_last
);

    logic                                    r_valid;
    logic signed [wetai_pkg::SampleBits-1:0] r_sample;
    logic                                    r_last;

    // free when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_last   = r_last;

endmodule
`default_nettype wire

// ----- src/wetai_core.sv -----
// per-waveform state: edge search, sample count and saturating window sum
`default_nettype none
module wetai_core #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_advance,
    input  wire logic signed [wetai_pkg::SampleBits-1:0] i_sample,
    input  wire logic                                    i_last,
    input  wire wetai_pkg::t_cfg                         i_cfg,
    output wetai_pkg::t_result                           o_result
);

    localparam int CntBits = $clog2(MAX_SAMPLES + 1);
    localparam int IdxW    = (CntBits > wetai_pkg::IndexBits) ? CntBits
                                                              : wetai_pkg::IndexBits;
    localparam int SumBits = wetai_pkg::SumBits;

    logic signed [wetai_pkg::SampleBits-1:0] r_recent0, r_recent1, r_recent2;
    logic signed [wetai_pkg::SampleBits-1:0] n_recent0, n_recent1, n_recent2;
    logic [CntBits-1:0]                      r_count, n_count;
    logic                                    r_seen, n_seen;
    logic [wetai_pkg::IndexBits-1:0]         r_edge_at, n_edge_at;
    logic signed [SumBits-1:0]               r_acc, n_acc;

    logic                                    w_active;
    logic [IdxW-1:0]                         w_n;
    logic [IdxW-1:0]                         w_n_minus2;
    logic                                    w_edge;
    logic                                    w_in_window;
    logic signed [SumBits:0]                 w_sum;

    // sample index widened for compares against the window registers
    assign w_n        = IdxW'(r_count);
    assign w_n_minus2 = w_n - IdxW'(2);
    assign w_active   = (r_count < CntBits'(MAX_SAMPLES));

    // below, above, above, above
    assign w_edge = !r_seen && (w_n >= IdxW'(3))
                    && (r_recent2 < i_cfg.threshold)
                    && (r_recent1 > i_cfg.threshold)
                    && (r_recent0 > i_cfg.threshold)
                    && (i_sample  > i_cfg.threshold);

    assign w_in_window = (w_n >= IdxW'(i_cfg.window_first))
                         && (w_n <= IdxW'(i_cfg.window_last));

    // one guard bit for the add, then clamp
    assign w_sum = {r_acc[SumBits-1], r_acc}
                   + (SumBits+1)'(i_sample);

    // next state for this sample
    always_comb begin
        n_recent0 = r_recent0;
        n_recent1 = r_recent1;
        n_recent2 = r_recent2;
        n_count   = r_count;
        n_seen    = r_seen;
        n_edge_at = r_edge_at;
        n_acc     = r_acc;
        if (w_active) begin
            if (w_edge) begin
                n_seen    = 1'b1;
                n_edge_at = w_n_minus2[wetai_pkg::IndexBits-1:0];
            end
            if (w_in_window) begin
                if (w_sum[SumBits] != w_sum[SumBits-1]) begin
                    n_acc = w_sum[SumBits] ? wetai_pkg::SumLow : wetai_pkg::SumHigh;
                end else begin
                    n_acc = w_sum[SumBits-1:0];
                end
            end
            n_recent2 = r_recent1;
            n_recent1 = r_recent0;
            n_recent0 = i_sample;
            n_count   = r_count + CntBits'(1);
        end
    end

    // result formed from the state after this sample
    always_comb begin
        o_result.edge_found = n_seen;
        o_result.edge_index = n_seen ? n_edge_at : '0;
        o_result.window_sum = n_acc;
    end

    // state register, cleared after the final sample of a waveform
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent0 <= '0;
            r_recent1 <= '0;
            r_recent2 <= '0;
            r_count   <= '0;
            r_seen    <= 1'b0;
            r_edge_at <= '0;
            r_acc     <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_recent0 <= '0;
                r_recent1 <= '0;
                r_recent2 <= '0;
                r_count   <= '0;
                r_seen    <= 1'b0;
                r_edge_at <= '0;
                r_acc     <= '0;
            end else begin
                r_recent0 <= n_recent0;
                r_recent1 <= n_recent1;
                r_recent2 <= n_recent2;
                r_count   <= n_count;
                r_seen    <= n_seen;
                r_edge_at <= n_edge_at;
                r_acc     <= n_acc;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/waveform_edge_time_and_integral.sv -----
// a result reaches the output via the input register and then the result register
// throughput: one sample per cycle when not stalled; the compare, count and saturating
// add of the core fit between the input register and the state and result registers
// a final sample waits in the input register while an earlier result is not yet taken
// reset (synchronous, active low) clears all waveform state, empties both stages and
// returns threshold 0, window_first 0, window_last 4095
`default_nettype none
module waveform_edge_time_and_integral #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample requests
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [15:0] sample
    input  wire logic        i_s_axis_tlast,   // end_of_wave
    // results
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [11:0] edge_index, [39:12] window_sum
    output logic             o_m_axis_tuser,   // edge_found
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [wetai_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  wire logic [wetai_pkg::CfgBits-1:0]    i_cfg_data
);

    wetai_pkg::t_cfg    r_cfg;
    wetai_pkg::t_result w_result;
    wetai_pkg::t_result r_out;
    logic               r_out_valid;

    logic                                    w_s1_valid;
    logic signed [wetai_pkg::SampleBits-1:0] w_s1_sample;
    logic                                    w_s1_last;
    logic                                    w_out_free;
    logic                                    w_s1_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= '0;
            r_cfg.window_first <= '0;
            r_cfg.window_last  <= wetai_pkg::WindowLastReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wetai_pkg::CfgThreshold: begin
                    r_cfg.threshold <= i_cfg_data[wetai_pkg::SampleBits-1:0];
                end
                wetai_pkg::CfgWindowFirst: begin
                    r_cfg.window_first <= i_cfg_data[wetai_pkg::IndexBits-1:0];
                end
                wetai_pkg::CfgWindowLast: begin
                    r_cfg.window_last <= i_cfg_data[wetai_pkg::IndexBits-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a final sample moves on only when the result register can take its result
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_s1_adv   = w_s1_valid && (!w_s1_last || w_out_free);

    wetai_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_sample  (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_advance (w_s1_adv),
        .o_valid   (w_s1_valid),
        .o_sample  (w_s1_sample),
        .o_last    (w_s1_last)
    );

    wetai_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_s1_adv),
        .i_sample  (w_s1_sample),
        .i_last    (w_s1_last),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && w_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_s1_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.window_sum, r_out.edge_index};
    assign o_m_axis_tuser  = r_out.edge_found;

    // no edge means index zero
    a_index_zero_without_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser || (o_m_axis_tdata[11:0] == 12'd0)))
        else $error("edge_index nonzero without an edge");

    // a result is only loaded into a free result register
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_s1_last) |-> w_out_free)
        else $error("result register overwritten");

    // input only stalls behind a final sample waiting for the result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (w_s1_valid && w_s1_last && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a blocked final sample");

endmodule
`default_nettype wire
